>>> design/sdil_pkg.sv
package sdil_pkg;

  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DUMP   = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED   = 3'd0,
    ST_DROPPED    = 3'd1,
    ST_REJECTED   = 3'd2,
    ST_DUMP_ENTRY = 3'd3,
    ST_DUMP_EMPTY = 3'd4
  } status_e;

  // one stored slot: sort key plus position
  typedef struct packed {
    logic        [COUNT_W-1:0] count;
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
    logic signed [POS_W-1:0]   z;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

>>> design/sdil_if.sv
interface sdil_in_if import sdil_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic        [COUNT_W-1:0] entry_count;
  logic signed [POS_W-1:0]   pos_x;
  logic signed [POS_W-1:0]   pos_y;
  logic signed [POS_W-1:0]   pos_z;

  modport source (output valid, opcode, entry_count, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, opcode, entry_count, pos_x, pos_y, pos_z, output ready);
endinterface

interface sdil_out_if import sdil_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic        [STATUS_W-1:0] status;
  logic        [COUNT_W-1:0]  out_count;
  logic signed [POS_W-1:0]    out_x;
  logic signed [POS_W-1:0]    out_y;
  logic signed [POS_W-1:0]    out_z;
  logic                       last;

  modport source (output valid, status, out_count, out_x, out_y, out_z, last, input ready);
  modport sink   (input valid, status, out_count, out_x, out_y, out_z, last, output ready);
endinterface

>>> design/sdil_ram.sv
module sdil_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/sorted_descending_insert_list_unit.sv
// channel | dir | modport | carries
// --------+-----+---------+--------------------------------------------------
// in_i    | in  | sink    | opcode, entry_count, pos_x, pos_y, pos_z
// out_o   | out | source  | status, out_count, out_x, out_y, out_z, last
//
// an insert compares and rewrites one slot per cycle over the single ram read
// port, then sends its result; a dump reads each shown entry, then checks and
// sends it, and the listing ends at the fill count or at a zero count
// reset clears the fill count but not the slots; slots at or past it are never read
// a stalled output holds a dump in place and an insert at its result; the next
// item is taken once the current one has put its last result into the output
// register
module sorted_descending_insert_list_unit import sdil_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sdil_in_if.sink     in_i,
  sdil_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_TAIL,
    S_RESP,
    S_DUMP_RD,
    S_DUMP_CHK,
    S_DUMP_FIN
  } state_e;

  // control
  state_e          state_q, state_d;
  logic   [FW-1:0] fill_q, fill_d;
  logic   [FW-1:0] idx_q, idx_d;
  logic            placed_q, placed_d;
  logic            out_valid_q, out_valid_d;

  // payload
  entry_t          new_q, new_d;
  entry_t          carry_q, carry_d;
  entry_t          pend_q, pend_d;
  status_e         status_q, status_d;
  status_e         out_status_q, out_status_d;
  entry_t          out_entry_q, out_entry_d;
  logic            out_last_q, out_last_d;

  // ram port
  logic            ram_we, ram_re;
  logic   [AW-1:0] ram_waddr, ram_raddr;
  entry_t          ram_wdata;
  logic   [ENTRY_W-1:0] ram_rdata;
  entry_t          rd;

  logic            in_xfer;
  logic            out_free;
  logic            full;
  logic            place_now;

  sdil_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd       = entry_t'(ram_rdata);
  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign full     = (fill_q == FW'(DEPTH));
  // new entry goes in front of the first slot whose count is not above its own
  assign place_now = !placed_q && (new_q.count >= rd.count);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    placed_d     = placed_q;
    new_d        = new_q;
    carry_d      = carry_q;
    pend_d       = pend_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[AW-1:0];
    ram_wdata    = new_q;
    ram_re       = 1'b0;
    ram_raddr    = idx_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          idx_d    = '0;
          placed_d = 1'b0;
          if (in_i.opcode == OP_INSERT) begin
            new_d.count = in_i.entry_count;
            new_d.x     = in_i.pos_x;
            new_d.y     = in_i.pos_y;
            new_d.z     = in_i.pos_z;
            if (fill_q == '0) begin
              state_d = S_TAIL;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_d   = S_WALK;
            end
          end else begin
            state_d = S_DUMP_RD;
          end
        end
      end

      // rd holds slot idx; once placed, write back slot idx, and fetch idx + 1 in the same cycle
      S_WALK: begin
        if (place_now) begin
          ram_we    = 1'b1;
          ram_wdata = new_q;
          carry_d   = rd;
          placed_d  = 1'b1;
        end else if (placed_q) begin
          ram_we    = 1'b1;
          ram_wdata = carry_q;
          carry_d   = rd;
        end
        if (idx_q != fill_q - FW'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_q + FW'(1));
          idx_d     = idx_q + FW'(1);
        end else if (!full) begin
          state_d = S_TAIL;
        end else begin
          // full: the bottom slot falls off, or the new entry ranks below all
          status_d = (placed_q || place_now) ? ST_DROPPED : ST_REJECTED;
          state_d  = S_RESP;
        end
      end

      // append at the first free slot: the pushed-down entry or the new one
      S_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_q[AW-1:0];
        ram_wdata = placed_q ? carry_q : new_q;
        fill_d    = fill_q + FW'(1);
        status_d  = ST_INSERTED;
        state_d   = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_entry_d  = '0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      S_DUMP_RD: begin
        if (idx_q < fill_q) begin
          ram_re  = 1'b1;
          state_d = S_DUMP_CHK;
        end else begin
          state_d = S_DUMP_FIN;
        end
      end

      // one entry is held back so the last flag is known when it is sent
      S_DUMP_CHK: begin
        if (rd.count == '0) begin
          state_d = S_DUMP_FIN;
        end else if (idx_q == '0) begin
          pend_d  = rd;
          idx_d   = idx_q + FW'(1);
          state_d = S_DUMP_RD;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_DUMP_ENTRY;
          out_entry_d  = pend_q;
          out_last_d   = 1'b0;
          pend_d       = rd;
          idx_d        = idx_q + FW'(1);
          state_d      = S_DUMP_RD;
        end
      end

      S_DUMP_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          if (idx_q == '0) begin
            out_status_d = ST_DUMP_EMPTY;
            out_entry_d  = '0;
          end else begin
            out_status_d = ST_DUMP_ENTRY;
            out_entry_d  = pend_q;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      idx_q        <= '0;
      placed_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      new_q        <= '0;
      carry_q      <= '0;
      pend_q       <= '0;
      status_q     <= ST_INSERTED;
      out_status_q <= ST_INSERTED;
      out_entry_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      idx_q        <= idx_d;
      placed_q     <= placed_d;
      out_valid_q  <= out_valid_d;
      new_q        <= new_d;
      carry_q      <= carry_d;
      pend_q       <= pend_d;
      status_q     <= status_d;
      out_status_q <= out_status_d;
      out_entry_q  <= out_entry_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.out_count = out_entry_q.count;
  assign out_o.out_x     = out_entry_q.x;
  assign out_o.out_y     = out_entry_q.y;
  assign out_o.out_z     = out_entry_q.z;
  assign out_o.last      = out_last_q;

  // fill count never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FW'(DEPTH))
    else $error("fill count above depth");

  // fill count only grows, one step at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + FW'(1)))
    else $error("fill count jumped");

  // slots are written only by the insert walk or the append
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_WALK || state_q == S_TAIL))
    else $error("slot write outside insert");

  // reads stay inside the filled part of the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (FW'(ram_raddr) < fill_q))
    else $error("read of unfilled slot");

endmodule
